// ===== hw/rtl/battery_and_high_voltage_supervisor_assert.svh =====
// Assertion macros shared by the supervisor RTL; expects clk and rst_n in scope.
`ifndef BATTERY_AND_HIGH_VOLTAGE_SUPERVISOR_ASSERT_SVH
`define BATTERY_AND_HIGH_VOLTAGE_SUPERVISOR_ASSERT_SVH

// Same-cycle implication.
`define BHV_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BHV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/bhv_pkg.sv =====
// Shared types, curve tables and codes for the battery and high-voltage supervisor.
package bhv_pkg;

  // Action codes of an input request
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_ARM    = 2'd1;
  localparam logic [1:0] ACT_DISARM = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_LOW_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_SLEEP_TIMEOUT = 2'd1;
  localparam logic [1:0] CFG_HV_MAX        = 2'd2;
  localparam logic [1:0] CFG_NOTIFY_STEP   = 2'd3;

  localparam logic [6:0]  LOW_THRESHOLD_RST = 7'd10;
  localparam logic [30:0] SLEEP_TIMEOUT_RST = 31'd300000;
  localparam logic [30:0] HV_MAX_RST        = 31'd600000;
  localparam logic [6:0]  NOTIFY_STEP_RST   = 7'd5;

  localparam logic [7:0] NOT_NOTIFIED = 8'hFF;

  // Discharge curve: clamp points and the eleven interior segments
  localparam logic [15:0] TOP_MV     = 16'd4200;
  localparam logic [15:0] BOTTOM_MV  = 16'd3000;
  localparam logic [6:0]  TOP_PCT    = 7'd100;
  localparam logic [6:0]  BOTTOM_PCT = 7'd0;

  localparam int SEGMENTS = 11;
  localparam int SEG_W    = $clog2(SEGMENTS);

  localparam logic [15:0] SEG_HI_MV [SEGMENTS] = '{
    16'd4200, 16'd4100, 16'd4000, 16'd3900, 16'd3800, 16'd3750,
    16'd3700, 16'd3600, 16'd3500, 16'd3400, 16'd3300
  };
  localparam logic [15:0] SEG_LO_MV [SEGMENTS] = '{
    16'd4100, 16'd4000, 16'd3900, 16'd3800, 16'd3750, 16'd3700,
    16'd3600, 16'd3500, 16'd3400, 16'd3300, 16'd3000
  };
  localparam logic [6:0] SEG_LO_PCT [SEGMENTS] = '{
    7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd25, 7'd15, 7'd8, 7'd4, 7'd0
  };
  // Percent rise per segment scaled to a common span of SEG_DEN millivolts
  localparam logic [5:0] SEG_COEF [SEGMENTS] = '{
    6'd30, 6'd30, 6'd30, 6'd30, 6'd60, 6'd60, 6'd45, 6'd30, 6'd21, 6'd12, 6'd4
  };
  localparam int SEG_DEN    = 300;
  localparam int OFS_W      = 9;   // offset into a segment stays below 300
  localparam int PROD_W     = 15;
  localparam int QUOT_STEPS = 14;  // ladder covers quotients up to 14; the curve needs 14
  localparam int QUOT_W     = 4;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now_ms;
    logic [6:0]  pct;
    logic        charger_active;
  } bhv_item_t;

  typedef struct packed {
    logic [6:0] battery_pct;
    logic       battery_low;
    logic       charging_now;
    logic       notify_pct;
    logic       notify_low;
    logic       hv_armed;
    logic       arm_refused;
    logic       hv_timed_out;
    logic       sleep_request;
  } bhv_result_t;

  typedef struct packed {
    logic        we;
    logic [1:0]  index;
    logic [30:0] wdata;
  } bhv_cfg_t;

endpackage

// ===== hw/rtl/battery_and_high_voltage_supervisor.sv =====
// Top level of the battery and high-voltage supervisor.
//
//   channel  | handshake             | payload
//   ---------+-----------------------+---------------------------------------------
//   in_      | in_valid / in_ready   | action, now_ms, battery_mv, charger_active
//   out_     | out_valid / out_ready | battery_pct .. sleep_request (one per request)
//   cfg_     | cfg_we                | cfg_index, cfg_wdata (no read-back)
//
// Throughput is one request per cycle while the output is not stalled. The front end
// converts millivolts to a percentage (segment compare, one small multiply, a
// divide-by-300 compare ladder) and writes the request into the queue; the back end
// updates the state and loads the result register. A request passes through the
// queue register and then the result register before it shows on the out_ port.
// Reset is synchronous and active low; it restores control state and configuration
// but not queue entries or result payload. When out_ready is low the result register
// holds, the queue fills up to QUEUE_DEPTH requests, and then in_ready drops.
module battery_and_high_voltage_supervisor #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_action,
  input  logic [31:0] in_now_ms,
  input  logic [15:0] in_battery_mv,
  input  logic        in_charger_active,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  out_battery_pct,
  output logic        out_battery_low,
  output logic        out_charging_now,
  output logic        out_notify_pct,
  output logic        out_notify_low,
  output logic        out_hv_armed,
  output logic        out_arm_refused,
  output logic        out_hv_timed_out,
  output logic        out_sleep_request,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [30:0] cfg_wdata
);
  import bhv_pkg::*;

  logic        q_full;
  logic        q_push;
  logic        q_pop;
  logic        q_not_empty;
  bhv_item_t   push_item;
  bhv_item_t   pop_item;
  bhv_cfg_t    cfg;
  bhv_result_t res;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.wdata = cfg_wdata;

  // Front: request intake and millivolt-to-percent conversion
  bhv_front u_front (
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_now_ms         (in_now_ms),
    .in_battery_mv     (in_battery_mv),
    .in_charger_active (in_charger_active),
    .q_full            (q_full),
    .q_push            (q_push),
    .q_item            (push_item)
  );

  // Decoupling queue so a stalled output does not freeze intake at once
  bhv_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_item  (pop_item)
  );

  // Back: arm/disarm, timeouts, notify tracking, result register
  bhv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_not_empty),
    .item      (pop_item),
    .q_pop     (q_pop),
    .res_valid (out_valid),
    .res_ready (out_ready),
    .res       (res)
  );

  assign out_battery_pct   = res.battery_pct;
  assign out_battery_low   = res.battery_low;
  assign out_charging_now  = res.charging_now;
  assign out_notify_pct    = res.notify_pct;
  assign out_notify_low    = res.notify_low;
  assign out_hv_armed      = res.hv_armed;
  assign out_arm_refused   = res.arm_refused;
  assign out_hv_timed_out  = res.hv_timed_out;
  assign out_sleep_request = res.sleep_request;

endmodule

// ===== hw/rtl/bhv_front.sv =====
// Front end: takes input requests and converts millivolts to a percentage.
module bhv_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_action,
  input  logic [31:0]         in_now_ms,
  input  logic [15:0]         in_battery_mv,
  input  logic                in_charger_active,
  input  logic                q_full,
  output logic                q_push,
  output bhv_pkg::bhv_item_t  q_item
);
  import bhv_pkg::*;

  logic [SEGMENTS-1:0]   hit;
  logic [SEG_W-1:0]      seg;
  logic [15:0]           ofs_full;
  logic [OFS_W-1:0]      ofs;
  logic [PROD_W-1:0]     prod;
  logic [QUOT_STEPS-1:0] ge;
  logic [QUOT_W-1:0]     quot;
  logic [6:0]            pct;

  always_comb begin
    for (int k = 0; k < SEGMENTS; k++) begin
      hit[k] = (in_battery_mv <= SEG_HI_MV[k]) && (in_battery_mv >= SEG_LO_MV[k]);
    end
    // lowest segment index wins where two share an end point
    seg = '0;
    for (int k = SEGMENTS - 1; k >= 0; k--) begin
      if (hit[k]) begin
        seg = SEG_W'(k);
      end
    end
  end

  assign ofs_full = in_battery_mv - SEG_LO_MV[seg];
  assign ofs      = ofs_full[OFS_W-1:0];
  assign prod     = PROD_W'(ofs) * PROD_W'(SEG_COEF[seg]);

  // divide by SEG_DEN through a short compare ladder
  always_comb begin
    for (int j = 0; j < QUOT_STEPS; j++) begin
      ge[j] = prod >= PROD_W'(SEG_DEN * (j + 1));
    end
  end
  assign quot = QUOT_W'($countones(ge));

  always_comb begin
    if (in_battery_mv >= TOP_MV) begin
      pct = TOP_PCT;
    end else if (in_battery_mv <= BOTTOM_MV) begin
      pct = BOTTOM_PCT;
    end else begin
      pct = SEG_LO_PCT[seg] + 7'(quot);
    end
  end

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.action         = in_action;
    q_item.now_ms         = in_now_ms;
    q_item.pct            = pct;
    q_item.charger_active = in_charger_active;
  end

endmodule

// ===== hw/rtl/bhv_queue.sv =====
// Small FIFO between the front end and the state back end.
`include "battery_and_high_voltage_supervisor_assert.svh"

module bhv_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  bhv_pkg::bhv_item_t push_item,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output bhv_pkg::bhv_item_t pop_item
);
  import bhv_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  bhv_item_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == FULL_CNT);
  assign not_empty = (cnt_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `BHV_ASSERT_IMPLY(q_no_overflow, push, !full || pop, "queue push while full")
  `BHV_ASSERT_IMPLY(q_no_underflow, pop, not_empty, "queue pop while empty")

endmodule

// ===== hw/rtl/bhv_back.sv =====
// Back end: supervisor state, configuration registers and the result register.
`include "battery_and_high_voltage_supervisor_assert.svh"

module bhv_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bhv_pkg::bhv_cfg_t    cfg,
  input  logic                 q_valid,
  input  bhv_pkg::bhv_item_t   item,
  output logic                 q_pop,
  output logic                 res_valid,
  input  logic                 res_ready,
  output bhv_pkg::bhv_result_t res
);
  import bhv_pkg::*;

  logic [6:0]  low_thr_r;
  logic [30:0] sleep_to_r;
  logic [30:0] hv_max_r;
  logic [6:0]  step_r;

  logic        armed_r, armed_nxt;
  logic [31:0] armed_since_r, armed_since_nxt;
  logic [31:0] last_act_r, last_act_nxt;
  logic [7:0]  last_note_r, last_note_nxt;
  logic [6:0]  pct_r, pct_nxt;
  logic        chg_r, chg_nxt;

  logic        res_valid_r, res_valid_nxt;
  bhv_result_t res_r, res_nxt;

  logic        take;
  logic [7:0]  pct8;
  logic [7:0]  diff;
  logic [31:0] arm_elapsed;
  logic [31:0] idle_elapsed;
  logic        notify;
  logic        timed_out;
  logic        sleep_req;
  logic        refused;

  assign take  = q_valid && (!res_valid_r || res_ready);
  assign q_pop = take;

  assign pct8         = {1'b0, item.pct};
  assign diff         = (pct8 > last_note_r) ? pct8 - last_note_r : last_note_r - pct8;
  assign notify       = (last_note_r == NOT_NOTIFIED) || (diff >= {1'b0, step_r});
  assign arm_elapsed  = item.now_ms - armed_since_r;
  assign idle_elapsed = item.now_ms - last_act_r;
  assign timed_out    = armed_r && (arm_elapsed > {1'b0, hv_max_r});
  // a timeout disarms, refreshing activity; sleep needs !armed_r, never both
  assign sleep_req    = !armed_r && (idle_elapsed > {1'b0, sleep_to_r});
  assign refused      = chg_r;

  always_comb begin
    armed_nxt       = armed_r;
    armed_since_nxt = armed_since_r;
    last_act_nxt    = last_act_r;
    last_note_nxt   = last_note_r;
    pct_nxt         = pct_r;
    chg_nxt         = chg_r;
    res_nxt         = res_r;
    res_valid_nxt   = res_valid_r && !res_ready;

    if (take) begin
      res_nxt       = '0;
      res_valid_nxt = 1'b1;
      case (item.action)
        ACT_SAMPLE: begin
          pct_nxt = item.pct;
          chg_nxt = item.charger_active;
          if (notify) begin
            last_note_nxt      = pct8;
            res_nxt.notify_pct = 1'b1;
          end
          res_nxt.notify_low = (item.pct <= low_thr_r) && !item.charger_active;
          if (timed_out) begin
            armed_nxt            = 1'b0;
            armed_since_nxt      = '0;
            last_act_nxt         = item.now_ms;
            res_nxt.hv_timed_out = 1'b1;
          end
          res_nxt.sleep_request = sleep_req;
        end
        ACT_ARM: begin
          if (refused) begin
            res_nxt.arm_refused = 1'b1;
          end else begin
            armed_nxt       = 1'b1;
            armed_since_nxt = item.now_ms;
            last_act_nxt    = item.now_ms;
          end
        end
        ACT_DISARM: begin
          armed_nxt       = 1'b0;
          armed_since_nxt = '0;
          last_act_nxt    = item.now_ms;
        end
        default: begin
        end
      endcase
      res_nxt.battery_pct  = pct_nxt;
      res_nxt.battery_low  = pct_nxt <= low_thr_r;
      res_nxt.charging_now = chg_nxt;
      res_nxt.hv_armed     = armed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_thr_r  <= LOW_THRESHOLD_RST;
      sleep_to_r <= SLEEP_TIMEOUT_RST;
      hv_max_r   <= HV_MAX_RST;
      step_r     <= NOTIFY_STEP_RST;
    end else if (cfg.we) begin
      case (cfg.index)
        CFG_LOW_THRESHOLD: low_thr_r  <= cfg.wdata[6:0];
        CFG_SLEEP_TIMEOUT: sleep_to_r <= cfg.wdata;
        CFG_HV_MAX:        hv_max_r   <= cfg.wdata;
        CFG_NOTIFY_STEP:   step_r     <= cfg.wdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r       <= 1'b0;
      armed_since_r <= '0;
      last_act_r    <= '0;
      last_note_r   <= NOT_NOTIFIED;
      pct_r         <= '0;
      chg_r         <= 1'b0;
      res_valid_r   <= 1'b0;
    end else begin
      armed_r       <= armed_nxt;
      armed_since_r <= armed_since_nxt;
      last_act_r    <= last_act_nxt;
      last_note_r   <= last_note_nxt;
      pct_r         <= pct_nxt;
      chg_r         <= chg_nxt;
      res_valid_r   <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  `BHV_ASSERT_NEXT(bk_take_loads, take, res_valid_r, "taken request left no result")
  `BHV_ASSERT_IMPLY(bk_timeout_alone, res_valid_r && res_r.hv_timed_out,
                    !res_r.sleep_request && !res_r.hv_armed, "timeout with sleep or armed")
  `BHV_ASSERT_IMPLY(bk_refused_chg, res_valid_r && res_r.arm_refused,
                    res_r.charging_now, "arm refused without charging")
  `BHV_ASSERT_IMPLY(bk_low_notify, res_valid_r && res_r.notify_low,
                    res_r.battery_low && !res_r.charging_now, "low notify inconsistent")

endmodule
